FILE: rtl/imsu_pkg.sv
// shared types, constants and address helpers for the ising metropolis spin update block
// no dependencies
`default_nettype none

package imsu_pkg;

  // lattice geometry
  localparam int unsigned SIDE   = 32;
  localparam int unsigned SIDE_W = $clog2(SIDE);
  localparam int unsigned SITES  = SIDE * SIDE;
  localparam int unsigned ADDR_W = 2 * SIDE_W;

  // field widths
  localparam int unsigned NSUM_W   = 4;
  localparam int unsigned ENERGY_W = 13;
  localparam int unsigned MAG_W    = 12;
  localparam int unsigned RND_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // one entry of the site memory: spin and the sum of the four neighbour spins
  typedef struct packed {
    logic                     spin;
    logic signed [NSUM_W-1:0] nsum;
  } imsu_site_t;

  localparam int unsigned SITE_W = $bits(imsu_site_t);

  localparam imsu_site_t SITE_RESET = '{spin: 1'b1, nsum: NSUM_W'(4)};

  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITES);
  localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITES);

  localparam logic [RND_W-1:0] TH_DE4_RESET = 32'd78665069;
  localparam logic [RND_W-1:0] TH_DE8_RESET = 32'd1440801;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TH_DE4 = 1'b0,
    CFG_TH_DE8 = 1'b1
  } imsu_cfg_e;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_FLIP = 1'b1
  } imsu_action_e;

  typedef enum logic [1:0] {
    NB_UP = 2'd0,
    NB_DN = 2'd1,
    NB_LF = 2'd2,
    NB_RT = 2'd3
  } imsu_nb_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_NB
  } imsu_state_e;

  // sequencer to datapath
  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clr_addr;
    logic              accept;
    logic              eval;
    logic              nb_step;
    logic [1:0]        nb_idx;
    logic              finish;
  } imsu_ctrl_t;

  function automatic logic [SIDE_W-1:0] wrap_dec(logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) r = SIDE_W'(SIDE - 1);
    else         r = v - 1'b1;
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] wrap_inc(logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == SIDE_W'(SIDE - 1)) r = '0;
    else                        r = v + 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] site_addr(logic [SIDE_W-1:0] r, logic [SIDE_W-1:0] c);
    return {r, c};
  endfunction

  function automatic logic [ADDR_W-1:0] nb_addr(logic [SIDE_W-1:0] r, logic [SIDE_W-1:0] c,
                                                logic [1:0] idx);
    logic [ADDR_W-1:0] a;
    case (idx)
      NB_UP:   a = site_addr(wrap_dec(r), c);
      NB_DN:   a = site_addr(wrap_inc(r), c);
      NB_LF:   a = site_addr(r, wrap_dec(c));
      NB_RT:   a = site_addr(r, wrap_inc(c));
      default: a = site_addr(r, c);
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/imsu_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read data
// no dependencies
`default_nettype none

module imsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/imsu_accept.sv
// acceptance decision for one site: load compare or metropolis test, plus energy change
// depends on imsu_pkg
`default_nettype none

module imsu_accept (
  input  wire logic                              action_i,
  input  wire logic                              want_i,
  input  wire imsu_pkg::imsu_site_t              site_i,
  input  wire logic [imsu_pkg::RND_W-1:0]        rnd_i,
  input  wire logic [imsu_pkg::RND_W-1:0]        th_de4_i,
  input  wire logic [imsu_pkg::RND_W-1:0]        th_de8_i,
  output      logic                              take_o,
  output      logic signed [imsu_pkg::NSUM_W:0]  de_o
);

  import imsu_pkg::*;

  // s * nsum, energy change is twice this
  logic signed [NSUM_W-1:0] prod;

  assign prod = site_i.spin ? site_i.nsum : -site_i.nsum;
  assign de_o = {prod, 1'b0};

  always_comb begin
    case (imsu_action_e'(action_i))
      ACT_LOAD: take_o = (site_i.spin != want_i);
      ACT_FLIP: begin
        if (prod <= 0)                  take_o = 1'b1;
        else if (prod == NSUM_W'(2))    take_o = (rnd_i < th_de4_i);
        else if (prod == NSUM_W'(4))    take_o = (rnd_i < th_de8_i);
        else                            take_o = 1'b0;
      end
      default: take_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/imsu_ctrl.sv
// sequencer: clearing pass after reset, then center read and four neighbour read-modify-writes
// depends on imsu_pkg
`default_nettype none

module imsu_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 take_i,
  output      logic                 busy,
  output      imsu_pkg::imsu_ctrl_t ctrl_o
);

  import imsu_pkg::*;

  imsu_state_e       state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [1:0]        nb_q, nb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      nb_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nb_q    <= nb_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    nb_d     = nb_q;
    busy     = 1'b1;
    ctrl_o   = '0;
    ctrl_o.clr_addr = clr_q;
    ctrl_o.nb_idx   = nb_q;
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        clr_d        = clr_q + 1'b1;
        if (clr_q == ADDR_W'(SITES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy          = 1'b0;
        ctrl_o.accept = start;
        if (start) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        ctrl_o.eval = 1'b1;
        nb_d        = '0;
        if (take_i) begin
          state_d = ST_NB;
        end else begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_NB: begin
        ctrl_o.nb_step = 1'b1;
        nb_d           = nb_q + 1'b1;
        if (nb_q == 2'(NB_RT)) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ising_metropolis_spin_update.sv
// top level of the ising metropolis spin update: site memory, totals, threshold registers
// depends on imsu_pkg, imsu_ram, imsu_accept, imsu_ctrl
`default_nettype none

// Single-site Metropolis update on a 32 x 32 periodic Ising lattice. Each site's spin and the
// sum of its four neighbour spins live in one 1024-entry memory with one write and one read
// port. After reset the block runs a clearing pass over all 1024 entries with busy high (config
// writes are still taken). An item is taken when start is high and busy is low. An item that
// leaves the spin unchanged holds busy only for the center read after the accepting edge; an
// item that changes the spin holds it on through the four neighbour read-modify-writes, done
// one per cycle through the single write port. The result shows on result_valid_o for one
// cycle, in the first cycle in which busy is low again, and must be taken then: there is no
// way to stall it. energy_o and magnetization_o are the totals after the item.
module ising_metropolis_spin_update (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic                                action_i,
  input  wire logic [imsu_pkg::SIDE_W-1:0]         row_i,
  input  wire logic [imsu_pkg::SIDE_W-1:0]         col_i,
  input  wire logic                                spin_value_i,
  input  wire logic [imsu_pkg::RND_W-1:0]          random_value_i,
  output      logic                                result_valid_o,
  output      logic                                flipped_o,
  output      logic                                site_spin_o,
  output      logic signed [imsu_pkg::ENERGY_W-1:0] energy_o,
  output      logic signed [imsu_pkg::MAG_W-1:0]   magnetization_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [imsu_pkg::RND_W-1:0]          cfg_data_i
);

  import imsu_pkg::*;

  imsu_ctrl_t ctrl;
  logic       take;
  logic signed [NSUM_W:0] de;

  logic [SIDE_W-1:0] row_q, col_q;
  logic              action_q, want_q;
  logic [RND_W-1:0]  rnd_q;
  logic              s_new_q;
  logic [RND_W-1:0]  th_de4_q, th_de8_q;
  logic signed [ENERGY_W-1:0] energy_q;
  logic signed [MAG_W-1:0]    mag_q;
  logic              flipped_q, site_spin_q, res_valid_q;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  imsu_site_t        wsite, rsite;
  logic [SITE_W-1:0] rdata;
  logic signed [NSUM_W-1:0] nsum_delta;

  imsu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .take_i (take),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  imsu_ram #(
    .WIDTH (SITE_W),
    .DEPTH (SITES)
  ) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wsite),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rsite = imsu_site_t'(rdata);

  imsu_accept u_accept (
    .action_i (action_q),
    .want_i   (want_q),
    .site_i   (rsite),
    .rnd_i    (rnd_q),
    .th_de4_i (th_de4_q),
    .th_de8_i (th_de8_q),
    .take_o   (take),
    .de_o     (de)
  );

  // read of the next entry is issued while the previous one is written back
  always_comb begin
    if (ctrl.accept)    raddr = site_addr(row_i, col_i);
    else if (ctrl.eval) raddr = nb_addr(row_q, col_q, 2'(NB_UP));
    else                raddr = nb_addr(row_q, col_q, ctrl.nb_idx + 2'd1);
  end

  assign nsum_delta = s_new_q ? NSUM_W'(2) : -NSUM_W'(2);

  always_comb begin
    we    = 1'b0;
    waddr = site_addr(row_q, col_q);
    wsite = rsite;
    if (ctrl.clear) begin
      we    = 1'b1;
      waddr = ctrl.clr_addr;
      wsite = SITE_RESET;
    end else if (ctrl.eval && take) begin
      we         = 1'b1;
      wsite.spin = ~rsite.spin;
    end else if (ctrl.nb_step) begin
      we         = 1'b1;
      waddr      = nb_addr(row_q, col_q, ctrl.nb_idx);
      wsite.nsum = rsite.nsum + nsum_delta;
    end
  end

  // item payload held for the whole sequence
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      row_q    <= row_i;
      col_q    <= col_i;
      action_q <= action_i;
      want_q   <= spin_value_i;
      rnd_q    <= random_value_i;
    end
    if (ctrl.eval) begin
      s_new_q     <= ~rsite.spin;
      flipped_q   <= take;
      site_spin_q <= take ? ~rsite.spin : rsite.spin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= ENERGY_RESET;
      mag_q       <= MAG_RESET;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl.finish;
      if (ctrl.clear) begin
        energy_q <= ENERGY_RESET;
        mag_q    <= MAG_RESET;
      end else if (ctrl.eval && take) begin
        energy_q <= energy_q + ENERGY_W'(de);
        mag_q    <= rsite.spin ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
      end
    end
  end

  // threshold registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_de4_q <= TH_DE4_RESET;
      th_de8_q <= TH_DE8_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (imsu_cfg_e'(cfg_index_i))
        CFG_TH_DE4: th_de4_q <= cfg_data_i;
        CFG_TH_DE8: th_de8_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign result_valid_o  = res_valid_q;
  assign flipped_o       = flipped_q;
  assign site_spin_o     = site_spin_q;
  assign energy_o        = energy_q;
  assign magnetization_o = mag_q;

  // a transfer in always starts a busy period
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy low right after an item was taken");

  // at most one result per item
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // totals only move in steps of four and two
  a_totals_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    energy_q[1:0] == 2'b00 && !mag_q[0])
    else $error("energy or magnetization lost its parity");

  // an item that does not flip leaves the totals alone
  a_no_flip_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !flipped_o |-> $stable(energy_q) && $stable(mag_q))
    else $error("totals changed without a flip");

endmodule

`default_nettype wire

FILE: verif/tb_ising_metropolis_spin_update.sv
// self-checking testbench for ising_metropolis_spin_update: loads and flips on the lattice,
// checked against an in-bench lattice model; depends on imsu_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_ising_metropolis_spin_update;
  import imsu_pkg::*;

  localparam int N           = SIDE;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    imsu_action_e      action;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    logic              spin_value;
    logic [RND_W-1:0]  rnd;
  } site_cmd_t;

  typedef struct packed {
    logic                       flipped;
    logic                       site_spin;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [MAG_W-1:0]    mag;
  } spin_result_t;

  logic                       clk_i;
  logic                       rst_ni         = 1'b0;
  logic                       start          = 1'b0;
  logic                       busy;
  logic                       action_i       = 1'b0;
  logic [SIDE_W-1:0]          row_i          = '0;
  logic [SIDE_W-1:0]          col_i          = '0;
  logic                       spin_value_i   = 1'b0;
  logic [RND_W-1:0]           random_value_i = '0;
  logic                       result_valid_o;
  logic                       flipped_o;
  logic                       site_spin_o;
  logic signed [ENERGY_W-1:0] energy_o;
  logic signed [MAG_W-1:0]    magnetization_o;
  logic                       cfg_valid_i    = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i    = '0;
  logic [RND_W-1:0]           cfg_data_i     = '0;

  ising_metropolis_spin_update dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .spin_value_i    (spin_value_i),
    .random_value_i  (random_value_i),
    .result_valid_o  (result_valid_o),
    .flipped_o       (flipped_o),
    .site_spin_o     (site_spin_o),
    .energy_o        (energy_o),
    .magnetization_o (magnetization_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // lattice model
  bit               lat_spin [SITES];
  int               lat_nsum [SITES];
  int               lat_energy;
  int               lat_mag;
  logic [RND_W-1:0] th_de4;
  logic [RND_W-1:0] th_de8;

  site_cmd_t    site_cmd_q [$];
  spin_result_t spin_result_q [$];
  site_cmd_t    cur_cmd;

  int  cmds_queued   = 0;
  int  results_seen  = 0;
  int  mismatch_cnt  = 0;
  int  cycle_cnt     = 0;
  int  gap_cnt       = 0;
  int  gap_pct       = 0;
  int  settings_cnt  = 1;
  int  flips_taken   = 0;
  int  flips_refused = 0;
  int  loads_changed = 0;
  int  loads_same    = 0;
  bit  cmd_taken;

  function automatic spin_result_t metropolis_step(site_cmd_t cmd);
    int           r, c, idx, s_old, d_e, step;
    bit           take;
    spin_result_t res;
    r     = int'(cmd.row);
    c     = int'(cmd.col);
    idx   = r * N + c;
    s_old = lat_spin[idx] ? 1 : -1;
    d_e   = 2 * s_old * lat_nsum[idx];
    if (cmd.action == ACT_LOAD) begin
      take = (lat_spin[idx] != cmd.spin_value);
      if (take) loads_changed++;
      else      loads_same++;
    end else begin
      if (d_e <= 0)      take = 1'b1;
      else if (d_e == 4) take = cmd.rnd < th_de4;
      else if (d_e == 8) take = cmd.rnd < th_de8;
      else               take = 1'b0;
      if (take) flips_taken++;
      else      flips_refused++;
    end
    if (take) begin
      step          = -2 * s_old;
      lat_spin[idx] = ~lat_spin[idx];
      lat_energy   += d_e;
      lat_mag      += step;
      lat_nsum[((r + N - 1) % N) * N + c] += step;
      lat_nsum[((r + 1) % N) * N + c]     += step;
      lat_nsum[r * N + (c + N - 1) % N]   += step;
      lat_nsum[r * N + (c + 1) % N]       += step;
    end
    res.flipped   = take;
    res.site_spin = lat_spin[idx];
    res.energy    = lat_energy[ENERGY_W-1:0];
    res.mag       = lat_mag[MAG_W-1:0];
    return res;
  endfunction

  task automatic queue_cmd(imsu_action_e act, int r, int c, bit sv, logic [RND_W-1:0] rnd);
    site_cmd_t cmd;
    cmd.action     = act;
    cmd.row        = SIDE_W'(r);
    cmd.col        = SIDE_W'(c);
    cmd.spin_value = sv;
    cmd.rnd        = rnd;
    site_cmd_q.push_back(cmd);
    cmds_queued++;
  endtask

  // half the sites come from a small patch so that neighbour sums interact
  task automatic queue_random_cmds(int count);
    int               anchor_r, anchor_c, win, r, c, pick;
    logic [RND_W-1:0] rnd;
    imsu_action_e     act;
    anchor_r = 0;
    anchor_c = 0;
    win      = 2;
    for (int k = 0; k < count; k++) begin
      if (k % 48 == 0) begin
        anchor_r = $urandom_range(0, N - 1);
        anchor_c = $urandom_range(0, N - 1);
        win      = $urandom_range(2, 6);
      end
      if ($urandom_range(0, 1)) begin
        r = (anchor_r + $urandom_range(0, win - 1)) % N;
        c = (anchor_c + $urandom_range(0, win - 1)) % N;
      end else begin
        r = $urandom_range(0, N - 1);
        c = $urandom_range(0, N - 1);
      end
      act  = ($urandom_range(0, 9) < 3) ? ACT_LOAD : ACT_FLIP;
      pick = $urandom_range(0, 9);
      if (pick < 4)       rnd = $urandom;
      else if (pick < 6)  rnd = th_de4 + RND_W'($urandom_range(0, 2)) - 1'b1;
      else if (pick < 8)  rnd = th_de8 + RND_W'($urandom_range(0, 2)) - 1'b1;
      else if (pick == 8) rnd = RND_W'($urandom_range(0, 255));
      else                rnd = $urandom_range(0, 1) ? '1 : '0;
      queue_cmd(act, r, c, 1'($urandom_range(0, 1)), rnd);
    end
  endtask

  task automatic write_threshold(imsu_cfg_e idx, logic [RND_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TH_DE4) th_de4 = val;
    else                   th_de8 = val;
  endtask

  task automatic wait_drained();
    while (results_seen < cmds_queued) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic new_thresholds(logic [RND_W-1:0] de4, logic [RND_W-1:0] de8);
    wait_drained();
    write_threshold(CFG_TH_DE4, de4);
    write_threshold(CFG_TH_DE8, de8);
    settings_cnt++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // driver: present the next command once the current one has transferred
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cmd_taken = start && !busy;
      if (cmd_taken) spin_result_q.push_back(metropolis_step(cur_cmd));
      if (!start || cmd_taken) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (site_cmd_q.size() > 0) begin
          cur_cmd         = site_cmd_q.pop_front();
          start          <= 1'b1;
          action_i       <= cur_cmd.action;
          row_i          <= cur_cmd.row;
          col_i          <= cur_cmd.col;
          spin_value_i   <= cur_cmd.spin_value;
          random_value_i <= cur_cmd.rnd;
          if ($urandom_range(0, 99) < gap_pct) gap_cnt = $urandom_range(1, 10);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be stalled, so every strobe is checked here
  always @(posedge clk_i) begin
    spin_result_t exp_res;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (spin_result_q.size() == 0) begin
        $error("result with no pending command");
        mismatch_cnt++;
      end else begin
        exp_res = spin_result_q.pop_front();
        if (flipped_o !== exp_res.flipped) begin
          $error("flipped: expected %0d, got %0d", exp_res.flipped, flipped_o);
          mismatch_cnt++;
        end
        if (site_spin_o !== exp_res.site_spin) begin
          $error("site_spin: expected %0d, got %0d", exp_res.site_spin, site_spin_o);
          mismatch_cnt++;
        end
        if (energy_o !== exp_res.energy) begin
          $error("energy: expected %0d, got %0d", exp_res.energy, energy_o);
          mismatch_cnt++;
        end
        if (magnetization_o !== exp_res.mag) begin
          $error("magnetization: expected %0d, got %0d", exp_res.mag, magnetization_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < SITES; k++) begin
      lat_spin[k] = 1'b1;
      lat_nsum[k] = 4;
    end
    lat_energy = -2 * SITES;
    lat_mag    = SITES;
    th_de4     = TH_DE4_RESET;
    th_de8     = TH_DE8_RESET;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset thresholds, every flip outcome, same-spin loads, wrap-around sites
    gap_pct = 20;
    queue_cmd(ACT_FLIP, 0, 0, 1'b0, '0);
    queue_cmd(ACT_FLIP, 0, 0, 1'b1, '1);
    queue_cmd(ACT_FLIP, 31, 31, 1'b0, '1);
    queue_cmd(ACT_LOAD, 31, 31, 1'b1, '0);
    queue_cmd(ACT_LOAD, 31, 31, 1'b0, '1);
    queue_cmd(ACT_LOAD, 31, 31, 1'b0, '0);
    queue_cmd(ACT_FLIP, 0, 31, 1'b0, TH_DE4_RESET - 1);
    queue_cmd(ACT_FLIP, 0, 31, 1'b1, '1);
    queue_cmd(ACT_FLIP, 0, 31, 1'b0, TH_DE4_RESET);
    queue_cmd(ACT_FLIP, 31, 0, 1'b0, TH_DE4_RESET + 1);
    queue_cmd(ACT_LOAD, 31, 0, 1'b0, '0);
    queue_cmd(ACT_LOAD, 30, 31, 1'b0, '0);
    queue_cmd(ACT_FLIP, 31, 31, 1'b1, '1);
    queue_cmd(ACT_FLIP, 31, 31, 1'b0, '1);
    queue_cmd(ACT_FLIP, 0, 0, 1'b0, TH_DE8_RESET - 1);
    queue_cmd(ACT_FLIP, 15, 16, 1'b0, TH_DE8_RESET - 1);
    queue_cmd(ACT_FLIP, 15, 16, 1'b1, '0);
    queue_cmd(ACT_FLIP, 16, 15, 1'b0, TH_DE8_RESET);
    queue_cmd(ACT_LOAD, 31, 0, 1'b1, '1);
    queue_cmd(ACT_LOAD, 0, 0, 1'b1, '0);
    queue_cmd(ACT_LOAD, 10, 21, 1'b0, 32'h5555_aaaa);
    queue_cmd(ACT_FLIP, 21, 10, 1'b1, 32'haaaa_5555);

    // zero thresholds: uphill flips never taken
    new_thresholds('0, '0);
    gap_pct = 30;
    queue_random_cmds(300);

    new_thresholds('1, '1);
    gap_pct = 60;
    queue_random_cmds(300);

    new_thresholds($urandom, $urandom_range(0, 32'h0fff_ffff));
    gap_pct = 15;
    queue_random_cmds(350);

    new_thresholds(32'h8000_0000, 32'd1);
    gap_pct = 40;
    queue_random_cmds(350);

    // last stretch back to back
    new_thresholds(TH_DE4_RESET, TH_DE8_RESET);
    gap_pct = 0;
    queue_random_cmds(350);

    wait_drained();
    $display("covered %0d commands under %0d threshold settings", cmds_queued, settings_cnt);
    $display("flips taken %0d, refused %0d; loads changed %0d, unchanged %0d",
             flips_taken, flips_refused, loads_changed, loads_same);
    if (spin_result_q.size() != 0) begin
      $error("%0d expected results never arrived", spin_result_q.size());
    end
    if (mismatch_cnt == 0 && spin_result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
